[hw/rtl/qcaw_pkg.sv]
// types and constants shared by the cluster address walker
package qcaw_pkg;

  localparam int unsigned BLOCK_W   = 40;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned WORD_W    = 64;
  localparam int unsigned ADDR_W    = 63;
  localparam int unsigned SHIFT_W   = 5;
  localparam int unsigned BSIZE_W   = 17;
  localparam int unsigned OFF_W     = BLOCK_W + 1 + BSIZE_W;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_BITS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_L2_BITS       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_L1_TABLE_BASE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_BLOCKS = 3'd4;

  localparam logic [SHIFT_W-1:0] CLUSTER_BITS_RST = 5'd12;
  localparam logic [SHIFT_W-1:0] L2_BITS_RST      = 5'd9;
  localparam logic [BSIZE_W-1:0] BLOCK_SIZE_RST   = 17'd512;

  typedef enum logic {
    OP_TRANSLATE = 1'b0,
    OP_TABLE_WORD = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_READ    = 2'd0,
    KIND_OFFSET  = 2'd1,
    KIND_UNALLOC = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_RANGE      = 2'd1,
    ERR_COMPRESSED = 2'd2,
    ERR_BUSY       = 2'd3
  } err_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [BLOCK_W-1:0]  first_block;
    logic [COUNT_W-1:0]  block_count;
    logic [WORD_W-1:0]   table_word;
  } in_item_t;

  typedef struct packed {
    kind_t               kind;
    logic [ADDR_W-1:0]   address;
    logic [COUNT_W-1:0]  block_index;
    err_t                error_code;
    logic                last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_ACCEPT = 3'b001,
    ST_MUL    = 3'b010,
    ST_L1     = 3'b100
  } state_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_WAIT_L1 = 3'b010,
    PH_WAIT_L2 = 3'b100
  } phase_t;

endpackage

[hw/rtl/qcow_cluster_address_walker_unit.sv]
// qcow cluster address walker: request checking, two-level table walk, offset report
// a translate request gives its first L1 read request after the steps accept, offset
// multiply and L1 address add; a table word gives its result in the next cycle, and
// the next block's L1 read request follows after the offset multiply and L1 address add
// input is stalled in the offset multiply and L1 address add states and while the output is held; one shared adder
// synchronous active-low reset: idle, run state cleared, registers at their defaults
module qcow_cluster_address_walker_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  qcaw_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output qcaw_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [qcaw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qcaw_pkg::ADDR_W-1:0]         cfg_wdata
);

  qcaw_pkg::state_t                   state_r, state_nxt;
  qcaw_pkg::phase_t                   phase_r, phase_nxt;
  logic [qcaw_pkg::BLOCK_W-1:0]       start_r, start_nxt;
  logic [qcaw_pkg::COUNT_W-1:0]       len_r, len_nxt;
  logic [qcaw_pkg::COUNT_W-1:0]       pos_r, pos_nxt;
  logic [qcaw_pkg::OFF_W-1:0]         off_r, off_nxt;
  logic                               out_valid_r, out_valid_nxt;
  qcaw_pkg::out_item_t                out_data_r, out_data_nxt;

  logic [qcaw_pkg::SHIFT_W-1:0]       cb_r;
  logic [qcaw_pkg::SHIFT_W-1:0]       lb_r;
  logic [qcaw_pkg::ADDR_W-1:0]        base_r;
  logic [qcaw_pkg::BSIZE_W-1:0]       bs_r;
  logic [qcaw_pkg::BLOCK_W-1:0]       devb_r;

  logic                               out_free;
  logic                               in_acc;
  logic [qcaw_pkg::SHIFT_W:0]         shamt;
  logic [qcaw_pkg::OFF_W-1:0]         shifted;
  logic [qcaw_pkg::OFF_W-1:0]         l2_mask;
  logic [qcaw_pkg::OFF_W-1:0]         c_mask;
  logic [qcaw_pkg::ADDR_W-1:0]        add_a;
  logic [qcaw_pkg::ADDR_W-1:0]        add_b;
  logic [qcaw_pkg::ADDR_W-1:0]        add_sum;
  logic [qcaw_pkg::BLOCK_W:0]         req_end;
  logic [qcaw_pkg::BLOCK_W:0]         blk_sum;
  logic [qcaw_pkg::COUNT_W-1:0]       pos_inc;
  logic                               word_zero;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == qcaw_pkg::ST_ACCEPT) && out_free);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // shared shifter: cluster+l2 bits for the L1 index, cluster bits for the L2 index
  always_comb begin
    if (state_r == qcaw_pkg::ST_L1) begin
      shamt = {1'b0, cb_r} + {1'b0, lb_r};
    end else begin
      shamt = {1'b0, cb_r};
    end
  end

  assign shifted = off_r >> shamt;
  assign l2_mask = ~({qcaw_pkg::OFF_W{1'b1}} << lb_r);
  assign c_mask  = ~({qcaw_pkg::OFF_W{1'b1}} << cb_r);

  // shared adder
  always_comb begin
    if (state_r == qcaw_pkg::ST_L1) begin
      add_a = base_r;
      add_b = {2'b00, shifted, 3'b000};
    end else begin
      add_a = in_data.table_word[qcaw_pkg::ADDR_W-1:0];
      if (phase_r == qcaw_pkg::PH_WAIT_L1) begin
        add_b = {2'b00, shifted & l2_mask, 3'b000};
      end else begin
        add_b = {5'b00000, off_r & c_mask};
      end
    end
  end

  assign add_sum   = add_a + add_b;
  assign req_end   = {1'b0, in_data.first_block} +
                     {{(qcaw_pkg::BLOCK_W+1-qcaw_pkg::COUNT_W){1'b0}}, in_data.block_count};
  assign blk_sum   = {1'b0, start_r} +
                     {{(qcaw_pkg::BLOCK_W+1-qcaw_pkg::COUNT_W){1'b0}}, pos_r};
  assign pos_inc   = pos_r + 16'd1;
  assign word_zero = (in_data.table_word == '0);

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    start_nxt     = start_r;
    len_nxt       = len_r;
    pos_nxt       = pos_r;
    off_nxt       = off_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    case (state_r)
      qcaw_pkg::ST_ACCEPT: begin
        if (in_acc) begin
          out_data_nxt.address     = '0;
          out_data_nxt.block_index = '0;
          out_data_nxt.error_code  = qcaw_pkg::ERR_NONE;
          out_data_nxt.last        = 1'b1;
          out_data_nxt.kind        = qcaw_pkg::KIND_ERROR;
          if (in_data.opcode == qcaw_pkg::OP_TRANSLATE) begin
            if (phase_r != qcaw_pkg::PH_IDLE) begin
              out_data_nxt.error_code = qcaw_pkg::ERR_BUSY;
              out_valid_nxt           = 1'b1;
            end else if (req_end > {1'b0, devb_r}) begin
              out_data_nxt.error_code = qcaw_pkg::ERR_RANGE;
              out_valid_nxt           = 1'b1;
            end else if (in_data.block_count != '0) begin
              start_nxt = in_data.first_block;
              len_nxt   = in_data.block_count;
              pos_nxt   = '0;
              state_nxt = qcaw_pkg::ST_MUL;
            end
          end else if (phase_r != qcaw_pkg::PH_IDLE) begin
            out_valid_nxt            = 1'b1;
            out_data_nxt.block_index = pos_r;
            if (in_data.table_word[qcaw_pkg::WORD_W-1]) begin
              out_data_nxt.error_code = qcaw_pkg::ERR_COMPRESSED;
              phase_nxt               = qcaw_pkg::PH_IDLE;
            end else if (word_zero || (phase_r == qcaw_pkg::PH_WAIT_L2)) begin
              // block done
              if (word_zero) begin
                out_data_nxt.kind = qcaw_pkg::KIND_UNALLOC;
              end else begin
                out_data_nxt.kind    = qcaw_pkg::KIND_OFFSET;
                out_data_nxt.address = add_sum;
              end
              pos_nxt = pos_inc;
              if (pos_inc >= len_r) begin
                phase_nxt = qcaw_pkg::PH_IDLE;
              end else begin
                out_data_nxt.last = 1'b0;
                state_nxt         = qcaw_pkg::ST_MUL;
              end
            end else begin
              out_data_nxt.kind    = qcaw_pkg::KIND_READ;
              out_data_nxt.address = add_sum;
              out_data_nxt.last    = 1'b0;
              phase_nxt            = qcaw_pkg::PH_WAIT_L2;
            end
          end
        end
      end
      qcaw_pkg::ST_MUL: begin
        off_nxt   = {{(qcaw_pkg::OFF_W-qcaw_pkg::BLOCK_W-1){1'b0}}, blk_sum} *
                    {{(qcaw_pkg::OFF_W-qcaw_pkg::BSIZE_W){1'b0}}, bs_r};
        state_nxt = qcaw_pkg::ST_L1;
      end
      qcaw_pkg::ST_L1: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.kind        = qcaw_pkg::KIND_READ;
          out_data_nxt.address     = add_sum;
          out_data_nxt.block_index = pos_r;
          out_data_nxt.error_code  = qcaw_pkg::ERR_NONE;
          out_data_nxt.last        = 1'b0;
          phase_nxt                = qcaw_pkg::PH_WAIT_L1;
          state_nxt                = qcaw_pkg::ST_ACCEPT;
        end
      end
      default: begin
        state_nxt = qcaw_pkg::ST_ACCEPT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qcaw_pkg::ST_ACCEPT;
      phase_r     <= qcaw_pkg::PH_IDLE;
      start_r     <= '0;
      len_r       <= '0;
      pos_r       <= '0;
      off_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      start_r     <= start_nxt;
      len_r       <= len_nxt;
      pos_r       <= pos_nxt;
      off_r       <= off_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cb_r   <= qcaw_pkg::CLUSTER_BITS_RST;
      lb_r   <= qcaw_pkg::L2_BITS_RST;
      base_r <= '0;
      bs_r   <= qcaw_pkg::BLOCK_SIZE_RST;
      devb_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        qcaw_pkg::REG_CLUSTER_BITS:  cb_r   <= cfg_wdata[qcaw_pkg::SHIFT_W-1:0];
        qcaw_pkg::REG_L2_BITS:       lb_r   <= cfg_wdata[qcaw_pkg::SHIFT_W-1:0];
        qcaw_pkg::REG_L1_TABLE_BASE: base_r <= cfg_wdata;
        qcaw_pkg::REG_BLOCK_SIZE:    bs_r   <= cfg_wdata[qcaw_pkg::BSIZE_W-1:0];
        qcaw_pkg::REG_DEVICE_BLOCKS: devb_r <= cfg_wdata[qcaw_pkg::BLOCK_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule
